// ===== hw/rtl/epmd_pkg.sv =====
// ----------------------------------------------------------------------------
// Encoder position and motor drive package
// Shared constants, operation and register codes, channel state type.
// ----------------------------------------------------------------------------
`default_nettype none

package epmd_pkg;

  // Number of encoder / motor channels
  localparam int CHANNELS = 3;
  // Width of the channel field on the ports
  localparam int CH_W = 2;
  // Index width into the per-channel state
  localparam int CH_IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  localparam int TICK_W  = 32;
  localparam int POS_W   = 16;
  localparam int DUTY_W  = 8;
  localparam int CFG_W   = 8;
  localparam int CFG_IDX_W = 2;

  localparam logic [DUTY_W-1:0] GAIN_RESET    = 8'd150;
  localparam logic [DUTY_W-1:0] LOCKOUT_RESET = 8'd1;
  localparam logic [DUTY_W-1:0] DUTY_MAX      = 8'd255;

  typedef enum logic [1:0] {
    OP_TICK    = 2'd0,
    OP_EDGE    = 2'd1,
    OP_COMPUTE = 2'd2
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MODE     = 2'd0,
    CFG_POLARITY = 2'd1,
    CFG_GAIN     = 2'd2,
    CFG_LOCKOUT  = 2'd3
  } cfg_idx_e;

  // State kept for one channel
  typedef struct packed {
    logic [TICK_W-1:0] last_tick;
    logic              await_rise;
    logic [POS_W-1:0]  count;
    logic [DUTY_W-1:0] duty;
    logic              dir;
  } chan_state_t;

  // Settings that apply to the channel under update
  typedef struct packed {
    logic              pos_mode;
    logic              polarity;
    logic [DUTY_W-1:0] gain;
    logic [DUTY_W-1:0] lockout;
  } chan_cfg_t;

endpackage

`default_nettype wire

// ===== hw/rtl/encoder_position_motor_drive_top.sv =====
// A transaction passes from the input register to the result register, through
// the channel update between them.
// Throughput: one transaction per cycle while the result channel is not held by
// back-pressure; the single channel update between the two registers sets it.
// Reset clears the tick count, all channel state and the settings
// (gain 150, lockout 1, others 0); no clearing pass is needed.
// ----------------------------------------------------------------------------
// Encoder position and motor drive top level
// Tick counter, per-channel quadrature counting and pwm command stage.
// ----------------------------------------------------------------------------
`default_nettype none

module encoder_position_motor_drive_top (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // configuration write port
  input  logic                           cfg_we_i,
  input  logic [epmd_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [epmd_pkg::CFG_W-1:0]     cfg_data_i,
  // input channel
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [1:0]                     operation_i,
  input  logic [1:0]                     channel_i,
  input  logic                           line_a_i,
  input  logic                           line_b_i,
  input  logic signed [15:0]             position_target_i,
  input  logic signed [15:0]             duty_target_i,
  // result channel
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [1:0]                     channel_out_o,
  output logic signed [15:0]             position_o,
  output logic [7:0]                     duty_o,
  output logic                           direction_o
);
  import epmd_pkg::*;

  // Settings
  logic [CHANNELS-1:0] mode_q;
  logic [CHANNELS-1:0] polarity_q;
  logic [DUTY_W-1:0]   gain_q;
  logic [DUTY_W-1:0]   lockout_q;

  // State
  logic [TICK_W-1:0]   tick_q;
  chan_state_t         chan_q [CHANNELS];

  // Input register
  logic                in_valid_q;
  logic [1:0]          op_q;
  logic [CH_W-1:0]     ch_q;
  logic                line_a_q;
  logic                line_b_q;
  logic [POS_W-1:0]    pos_t_q;
  logic [POS_W-1:0]    duty_t_q;

  // Result register
  logic                out_valid_q;
  logic [CH_W-1:0]     ch_out_q;
  logic [POS_W-1:0]    position_q;
  logic [DUTY_W-1:0]   duty_q;
  logic                dir_q;

  logic                advance;
  logic                ch_valid;
  logic [CH_IDX_W-1:0] ch_idx;
  chan_cfg_t           upd_cfg;
  chan_state_t         cur_state;
  chan_state_t         nxt_state;

  // Handshake: the stage moves when the result register is free or draining
  assign advance    = !out_valid_q || out_ready_i;
  assign in_ready_o = !in_valid_q || advance;

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= '0;
      polarity_q <= '0;
      gain_q     <= GAIN_RESET;
      lockout_q  <= LOCKOUT_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_MODE:     mode_q     <= cfg_data_i[CHANNELS-1:0];
        CFG_POLARITY: polarity_q <= cfg_data_i[CHANNELS-1:0];
        CFG_GAIN:     gain_q     <= cfg_data_i[DUTY_W-1:0];
        CFG_LOCKOUT:  lockout_q  <= cfg_data_i[DUTY_W-1:0];
        default:      ;
      endcase
    end
  end

  // Capture the input transaction
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      op_q     <= operation_i;
      ch_q     <= channel_i;
      line_a_q <= line_a_i;
      line_b_q <= line_b_i;
      pos_t_q  <= position_target_i;
      duty_t_q <= duty_target_i;
    end
  end

  // Pick the addressed channel
  assign ch_valid  = (int'(ch_q) < CHANNELS);
  assign ch_idx    = ch_q[CH_IDX_W-1:0];
  assign cur_state = ch_valid ? chan_q[ch_idx] : '0;
  assign upd_cfg   = '{pos_mode: ch_valid ? mode_q[ch_idx] : 1'b0,
                       polarity: ch_valid ? polarity_q[ch_idx] : 1'b0,
                       gain:     gain_q,
                       lockout:  lockout_q};

  epmd_chan_upd u_chan_upd (
    .op_i              (op_q),
    .line_a_i          (line_a_q),
    .line_b_i          (line_b_q),
    .position_target_i (pos_t_q),
    .duty_target_i     (duty_t_q),
    .tick_count_i      (tick_q),
    .cfg_i             (upd_cfg),
    .state_i           (cur_state),
    .state_o           (nxt_state)
  );

  // Advance the tick count and write back the channel state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_q <= '0;
      for (int i = 0; i < CHANNELS; i++) begin
        chan_q[i] <= '0;
      end
    end else if (in_valid_q && advance) begin
      if (op_e'(op_q) == OP_TICK) begin
        tick_q <= tick_q + {{(TICK_W-1){1'b0}}, 1'b1};
      end
      if (ch_valid) begin
        chan_q[ch_idx] <= nxt_state;
      end
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= in_valid_q;
    end
  end

  // Report zeros for a channel outside the implemented set
  always_ff @(posedge clk_i) begin
    if (advance && in_valid_q) begin
      ch_out_q   <= ch_q;
      position_q <= ch_valid ? nxt_state.count : '0;
      duty_q     <= ch_valid ? nxt_state.duty : '0;
      dir_q      <= ch_valid ? nxt_state.dir : 1'b0;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign channel_out_o = ch_out_q;
  assign position_o    = position_q;
  assign duty_o        = duty_q;
  assign direction_o   = dir_q;

endmodule

`default_nettype wire

// ===== hw/rtl/epmd_chan_upd.sv =====
// ----------------------------------------------------------------------------
// Channel update
// Next state of one channel for an edge or compute transaction.
// ----------------------------------------------------------------------------
`default_nettype none

module epmd_chan_upd (
  input  logic [1:0]                  op_i,
  input  logic                        line_a_i,
  input  logic                        line_b_i,
  input  logic [15:0]                 position_target_i,
  input  logic [15:0]                 duty_target_i,
  input  logic [31:0]                 tick_count_i,
  input  epmd_pkg::chan_cfg_t         cfg_i,
  input  epmd_pkg::chan_state_t       state_i,
  output epmd_pkg::chan_state_t       state_o
);
  import epmd_pkg::*;

  logic [TICK_W-1:0] elapsed;
  logic              edge_open;
  logic [POS_W-1:0]  count_inc;
  logic [POS_W-1:0]  count_dec;
  logic [POS_W-1:0]  duty_neg;
  logic [POS_W-1:0]  pos_err;
  logic              err_zero;
  logic [DUTY_W-1:0] pwm_duty;
  logic              pwm_dir;

  // Lockout window and counter steps
  assign elapsed   = tick_count_i - state_i.last_tick;
  assign edge_open = elapsed > {{(TICK_W-DUTY_W){1'b0}}, cfg_i.lockout};
  assign count_inc = state_i.count + {{(POS_W-1){1'b0}}, 1'b1};
  assign count_dec = state_i.count - {{(POS_W-1){1'b0}}, 1'b1};

  // Direct pwm: sign gives direction, magnitude saturates
  assign duty_neg = {POS_W{1'b0}} - duty_target_i;
  always_comb begin
    if (duty_target_i != '0 && !duty_target_i[POS_W-1]) begin
      pwm_dir  = 1'b0;
      pwm_duty = (duty_target_i > {{(POS_W-DUTY_W){1'b0}}, DUTY_MAX}) ?
                 DUTY_MAX : duty_target_i[DUTY_W-1:0];
    end else begin
      pwm_dir  = 1'b1;
      pwm_duty = (duty_neg > {{(POS_W-DUTY_W){1'b0}}, DUTY_MAX}) ?
                 DUTY_MAX : duty_neg[DUTY_W-1:0];
    end
  end

  // Position error against the current count
  assign pos_err  = position_target_i - state_i.count;
  assign err_zero = (pos_err == '0);

  // Select the next channel state
  always_comb begin
    state_o = state_i;
    case (op_e'(op_i))
      OP_EDGE: begin
        if (edge_open) begin
          if (state_i.await_rise && line_a_i) begin
            state_o.count      = line_b_i ? count_inc : count_dec;
            state_o.await_rise = 1'b0;
            state_o.last_tick  = tick_count_i;
          end else if (!state_i.await_rise && !line_a_i) begin
            state_o.count      = line_b_i ? count_dec : count_inc;
            state_o.await_rise = 1'b1;
            state_o.last_tick  = tick_count_i;
          end
        end
      end
      OP_COMPUTE: begin
        if (!cfg_i.pos_mode) begin
          state_o.duty = pwm_duty;
          state_o.dir  = pwm_dir;
        end else begin
          state_o.dir  = (!err_zero && !pos_err[POS_W-1]) ?
                         ~cfg_i.polarity : cfg_i.polarity;
          state_o.duty = err_zero ? '0 : cfg_i.gain;
        end
      end
      default: begin
        state_o = state_i;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== test/tb_encoder_position_motor_drive_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Encoder position and motor drive testbench
// Drives tick, encoder edge and compute transactions through the valid/ready
// input channel. A behavioural predictor works out each expected result when
// the transaction is accepted. The checker compares every returned result,
// field by field, against the oldest prediction. Both handshakes idle at
// random, and the settings are changed between phases, extremes included.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_encoder_position_motor_drive_top;
  import epmd_pkg::*;

  localparam logic [1:0] OP_UNUSED      = 2'd3;
  localparam logic [1:0] CH_NONE        = 2'd3;
  localparam int         RESULT_LATENCY = 2;
  localparam int         STALL_LIMIT    = 5000;

  typedef struct packed {
    logic [1:0]        channel;
    logic signed [15:0] position;
    logic [7:0]        duty;
    logic              direction;
  } drive_result_t;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [CFG_W-1:0]     cfg_data_i;
  logic                 in_valid_i;
  logic                 in_ready_o;
  logic [1:0]           operation_i;
  logic [1:0]           channel_i;
  logic                 line_a_i;
  logic                 line_b_i;
  logic signed [15:0]   position_target_i;
  logic signed [15:0]   duty_target_i;
  logic                 out_valid_o;
  logic                 out_ready_i;
  logic [1:0]           channel_out_o;
  logic signed [15:0]   position_o;
  logic [7:0]           duty_o;
  logic                 direction_o;

  // Predictor copy of the block state and settings
  logic [31:0] sim_ticks;
  logic [31:0] sim_edge_tick  [CHANNELS];
  logic        sim_rise_armed [CHANNELS];
  logic [15:0] sim_count      [CHANNELS];
  logic [7:0]  sim_duty       [CHANNELS];
  logic        sim_dir        [CHANNELS];
  logic [2:0]  set_mode;
  logic [2:0]  set_polarity;
  logic [7:0]  set_gain;
  logic [7:0]  set_lockout;

  drive_result_t drive_expect_q[$];
  int            mismatch_count;
  int            stall_cycles;
  logic          idle_on;

  encoder_position_motor_drive_top u_top (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_idx_i         (cfg_idx_i),
    .cfg_data_i        (cfg_data_i),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .operation_i       (operation_i),
    .channel_i         (channel_i),
    .line_a_i          (line_a_i),
    .line_b_i          (line_b_i),
    .position_target_i (position_target_i),
    .duty_target_i     (duty_target_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .channel_out_o     (channel_out_o),
    .position_o        (position_o),
    .duty_o            (duty_o),
    .direction_o       (direction_o)
  );

  // Clock, 12 ns period
  always begin
    clk_i = 1'b1;
    #6;
    clk_i = 1'b0;
    #6;
  end

  // Advance the predicted state by one transaction and return its result
  function automatic drive_result_t predict_drive(logic [1:0] op, logic [1:0] ch, logic a,
                                                  logic b, logic [15:0] pos_ref,
                                                  logic [15:0] duty_ref);
    drive_result_t res;
    logic [15:0]   err;
    logic [15:0]   mag;
    logic          pol;
    res         = '0;
    res.channel = ch;
    if (op == OP_TICK) begin
      sim_ticks = sim_ticks + 32'd1;
    end else if (ch < CHANNELS && op == OP_EDGE) begin
      // Edges inside the lockout window, or not awaited, are dropped
      if ((sim_ticks - sim_edge_tick[ch]) > {24'd0, set_lockout}) begin
        if (sim_rise_armed[ch] && a) begin
          sim_count[ch]      = b ? sim_count[ch] + 16'd1 : sim_count[ch] - 16'd1;
          sim_rise_armed[ch] = 1'b0;
          sim_edge_tick[ch]  = sim_ticks;
        end else if (!sim_rise_armed[ch] && !a) begin
          sim_count[ch]      = b ? sim_count[ch] - 16'd1 : sim_count[ch] + 16'd1;
          sim_rise_armed[ch] = 1'b1;
          sim_edge_tick[ch]  = sim_ticks;
        end
      end
    end else if (ch < CHANNELS && op == OP_COMPUTE) begin
      pol = set_polarity[ch];
      if (!set_mode[ch]) begin
        // Direct pwm: sign picks direction, magnitude saturates at full duty
        if (duty_ref != 16'd0 && !duty_ref[15]) begin
          sim_duty[ch] = (duty_ref > 16'd255) ? DUTY_MAX : duty_ref[7:0];
          sim_dir[ch]  = 1'b0;
        end else begin
          mag          = ~duty_ref + 16'd1;
          sim_duty[ch] = (mag > 16'd255) ? DUTY_MAX : mag[7:0];
          sim_dir[ch]  = 1'b1;
        end
      end else begin
        // Position control: error sign and polarity give direction
        err          = pos_ref - sim_count[ch];
        sim_dir[ch]  = (err != 16'd0 && !err[15]) ? ~pol : pol;
        sim_duty[ch] = (err == 16'd0) ? 8'd0 : set_gain;
      end
    end
    if (ch < CHANNELS) begin
      res.position  = sim_count[ch];
      res.duty      = sim_duty[ch];
      res.direction = sim_dir[ch];
    end
    return res;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t: %s mismatch: got %0d, expected %0d", $realtime, what, got, want);
    mismatch_count++;
  endtask

  // Predict on every accepted input transaction
  always @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      drive_expect_q.push_back(predict_drive(operation_i, channel_i, line_a_i, line_b_i,
                                             position_target_i, duty_target_i));
    end
  end

  // Check every accepted result against the oldest prediction
  always @(posedge clk_i) begin
    drive_result_t want;
    if (out_valid_o && out_ready_i) begin
      if (drive_expect_q.size() == 0) begin
        report_mismatch("unexpected result, channel", 32'(channel_out_o), 32'd0);
      end else begin
        want = drive_expect_q.pop_front();
        if (channel_out_o !== want.channel)
          report_mismatch("channel", 32'(channel_out_o), 32'(want.channel));
        if (position_o !== want.position)
          report_mismatch("position", 32'(position_o), 32'(want.position));
        if (duty_o !== want.duty)
          report_mismatch("duty", 32'(duty_o), 32'(want.duty));
        if (direction_o !== want.direction)
          report_mismatch("direction", 32'(direction_o), 32'(want.direction));
      end
    end
  end

  // Result back-pressure
  always @(negedge clk_i) begin
    out_ready_i <= !(idle_on && $urandom_range(99) < 6);
  end

  // Count cycles without any transaction on either channel
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
  end

  initial begin
    stall_cycles = 0;
    @(posedge rst_ni);
    while (stall_cycles < STALL_LIMIT) @(posedge clk_i);
    $display("encoder_position_motor_drive_top verification failed");
    $finish;
  end

  // Send one transaction; called and returns at a falling edge
  task automatic send_item(input logic [1:0] op, input logic [1:0] ch, input logic a,
                           input logic b, input logic signed [15:0] pos_ref,
                           input logic signed [15:0] duty_ref);
    while (idle_on && $urandom_range(99) < 6) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i        <= 1'b1;
    operation_i       <= op;
    channel_i         <= ch;
    line_a_i          <= a;
    line_b_i          <= b;
    position_target_i <= pos_ref;
    duty_target_i     <= duty_ref;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
  endtask

  // Drop valid and wait until every predicted result has come back
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (drive_expect_q.size() != 0) @(negedge clk_i);
  endtask

  task automatic write_setting(input cfg_idx_e idx, input logic [7:0] value);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
    case (idx)
      CFG_MODE:     set_mode     = value[2:0];
      CFG_POLARITY: set_polarity = value[2:0];
      CFG_GAIN:     set_gain     = value;
      CFG_LOCKOUT:  set_lockout  = value;
      default: ;
    endcase
  endtask

  task automatic apply_settings(input logic [7:0] mode, input logic [7:0] pol,
                                input logic [7:0] gain, input logic [7:0] lockout);
    wait_idle();
    write_setting(CFG_MODE, mode);
    write_setting(CFG_POLARITY, pol);
    write_setting(CFG_GAIN, gain);
    write_setting(CFG_LOCKOUT, lockout);
  endtask

  // Reset state, unused operation code and an out-of-range channel
  task automatic test_reset_state();
    send_item(OP_TICK, 2'd1, 1'b0, 1'b0, 16'sd0, 16'sd0);
    send_item(OP_UNUSED, 2'd2, 1'b1, 1'b1, 16'sh7fff, 16'sh7fff);
    send_item(OP_COMPUTE, CH_NONE, 1'b1, 1'b0, -16'sd1, 16'sd100);
  endtask

  // Pwm mode at the duty extremes, both signs and saturation
  task automatic test_pwm_extremes();
    logic signed [15:0] refs[9];
    refs = '{16'sd0, 16'sd1, 16'sd255, 16'sd256, 16'sh7fff,
             -16'sd1, -16'sd255, -16'sd256, 16'sh8000};
    foreach (refs[i]) send_item(OP_COMPUTE, 2'(i % 3), 1'b0, 1'b0, 16'sd0, refs[i]);
  endtask

  // Lockout rejection, unawaited edge, count wrap below zero, both B levels
  task automatic test_encoder_edges();
    send_item(OP_EDGE, 2'd0, 1'b0, 1'b0, 16'sd0, 16'sd0);
    send_item(OP_TICK, 2'd0, 1'b0, 1'b0, 16'sd0, 16'sd0);
    send_item(OP_TICK, 2'd0, 1'b0, 1'b0, 16'sd0, 16'sd0);
    send_item(OP_EDGE, 2'd0, 1'b1, 1'b1, 16'sd0, 16'sd0);
    send_item(OP_EDGE, 2'd0, 1'b0, 1'b1, 16'sd0, 16'sd0);
    send_item(OP_EDGE, 2'd0, 1'b1, 1'b1, 16'sd0, 16'sd0);
    send_item(OP_TICK, 2'd2, 1'b0, 1'b0, 16'sd0, 16'sd0);
    send_item(OP_TICK, 2'd1, 1'b0, 1'b0, 16'sd0, 16'sd0);
    send_item(OP_EDGE, 2'd0, 1'b1, 1'b0, 16'sd0, 16'sd0);
    send_item(OP_EDGE, 2'd1, 1'b0, 1'b0, 16'sd0, 16'sd0);
  endtask

  // Position mode: zero, positive, negative and most negative error
  task automatic test_position_mode();
    apply_settings(8'd7, 8'd5, 8'd255, 8'd1);
    send_item(OP_COMPUTE, 2'd0, 1'b0, 1'b0, -16'sd2, 16'sd0);
    send_item(OP_COMPUTE, 2'd1, 1'b0, 1'b0, 16'sd100, 16'sd0);
    send_item(OP_COMPUTE, 2'd2, 1'b0, 1'b0, 16'sh8000, 16'sd0);
    send_item(OP_COMPUTE, 2'd0, 1'b0, 1'b0, 16'sh7fff, 16'sd0);
    apply_settings(8'd7, 8'd0, 8'd0, 8'd1);
    send_item(OP_COMPUTE, 2'd1, 1'b0, 1'b0, -16'sd5, -16'sd5);
  endtask

  // Mostly well-formed quadrature traffic, with targets near the count
  task automatic random_traffic(input int n_items, input int tick_pct);
    int                 pick;
    logic [1:0]         ch;
    logic               a;
    logic signed [15:0] pos_ref;
    logic signed [15:0] duty_ref;
    for (int i = 0; i < n_items; i++) begin
      pick     = $urandom_range(99);
      ch       = 2'($urandom_range(2));
      pos_ref  = 16'($urandom);
      duty_ref = 16'($urandom);
      if (pick < tick_pct) begin
        send_item(OP_TICK, 2'($urandom_range(3)), 1'($urandom), 1'($urandom), pos_ref,
                  duty_ref);
      end else begin
        pick = $urandom_range(99);
        if (pick < 55) begin
          // Follow the awaited level most of the time
          a = ($urandom_range(99) < 85) ? sim_rise_armed[ch] : 1'($urandom);
          send_item(OP_EDGE, ch, a, 1'($urandom), pos_ref, duty_ref);
        end else if (pick < 92) begin
          if ($urandom_range(1))
            pos_ref = sim_count[ch] + 16'($urandom_range(6)) - 16'd3;
          if ($urandom_range(1))
            duty_ref = 16'($urandom_range(600)) - 16'sd300;
          send_item(OP_COMPUTE, ch, 1'b0, 1'b0, pos_ref, duty_ref);
        end else if (pick < 96) begin
          send_item(OP_UNUSED, 2'($urandom_range(3)), 1'($urandom), 1'($urandom), pos_ref,
                    duty_ref);
        end else begin
          send_item(2'($urandom_range(2)), CH_NONE, 1'($urandom), 1'($urandom), pos_ref,
                    duty_ref);
        end
      end
    end
  endtask

  initial begin
    rst_ni            = 1'b0;
    cfg_we_i          = 1'b0;
    cfg_idx_i         = CFG_MODE;
    cfg_data_i        = '0;
    in_valid_i        = 1'b0;
    operation_i       = OP_TICK;
    channel_i         = '0;
    line_a_i          = 1'b0;
    line_b_i          = 1'b0;
    position_target_i = '0;
    duty_target_i     = '0;
    out_ready_i       = 1'b0;
    idle_on           = 1'b1;
    mismatch_count    = 0;
    sim_ticks         = '0;
    for (int c = 0; c < CHANNELS; c++) begin
      sim_edge_tick[c]  = '0;
      sim_rise_armed[c] = 1'b0;
      sim_count[c]      = '0;
      sim_duty[c]       = '0;
      sim_dir[c]        = 1'b0;
    end
    set_mode     = '0;
    set_polarity = '0;
    set_gain     = GAIN_RESET;
    set_lockout  = LOCKOUT_RESET;

    // Hold reset, then release it on a falling edge
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_reset_state();
    test_pwm_extremes();
    test_encoder_edges();
    test_position_mode();

    apply_settings(8'd0, 8'd0, 8'd150, 8'd1);
    random_traffic(400, 35);
    // Long stretch with no idling on either side
    idle_on = 1'b0;
    apply_settings(8'd7, 8'd2, 8'd255, 8'd0);
    random_traffic(400, 35);
    idle_on = 1'b1;
    apply_settings(8'd5, 8'd7, 8'd0, 8'd3);
    random_traffic(400, 35);
    apply_settings(8'd2, 8'd5, 8'($urandom), 8'd255);
    random_traffic(600, 90);

    wait_idle();
    repeat (RESULT_LATENCY + 2) @(posedge clk_i);
    if (drive_expect_q.size() != 0)
      report_mismatch("results outstanding at end", drive_expect_q.size(), 0);
    if (mismatch_count == 0)
      $display("encoder_position_motor_drive_top verification clean");
    else
      $display("encoder_position_motor_drive_top verification failed");
    $finish;
  end

endmodule

`default_nettype wire

// ===== filelist.f =====
hw/rtl/epmd_pkg.sv
hw/rtl/epmd_chan_upd.sv
hw/rtl/encoder_position_motor_drive_top.sv
test/tb_encoder_position_motor_drive_top.sv
